>>> src/swut_pkg.sv
// shared types and constants of the single-wire uart transaction block
`default_nettype none
package swut_pkg;

  localparam int unsigned BitTicksW   = 16;
  localparam int unsigned TimeoutW    = 20;
  localparam int unsigned GuardW      = 4;
  localparam int unsigned ReplyW      = 5;
  localparam int unsigned TimerW      = 17;
  localparam int unsigned IndexW      = 4;
  localparam int unsigned ApbAddrW    = 4;
  localparam int unsigned ApbDataW    = 32;

  localparam logic [BitTicksW-1:0] BitTicksRst = 16'd3750;
  localparam logic [TimeoutW-1:0]  TimeoutRst  = 20'd20000;
  localparam logic [GuardW-1:0]    GuardRst    = 4'd4;
  localparam logic [ReplyW-1:0]    ReplyRst    = 5'd8;

  localparam logic [BitTicksW-1:0] BitTicksMin = 16'd2;
  localparam logic [ReplyW-1:0]    ReplyMax    = 5'd16;
  localparam logic [IndexW-1:0]    TxBits      = 4'd10;
  localparam logic [IndexW-1:0]    RxBits      = 4'd8;
  localparam logic [7:0]           TimeoutByte = 8'hFF;

  typedef enum logic [1:0] {
    REG_BIT_TICKS = 2'd0,
    REG_TIMEOUT   = 2'd1,
    REG_GUARD     = 2'd2,
    REG_REPLY     = 2'd3
  } reg_idx_t;

  typedef enum logic [6:0] {
    PH_IDLE  = 7'b0000001,
    PH_HOLD  = 7'b0000010,
    PH_TX    = 7'b0000100,
    PH_WAIT  = 7'b0001000,
    PH_BITS  = 7'b0010000,
    PH_TAIL  = 7'b0100000,
    PH_GUARD = 7'b1000000
  } phase_t;

  typedef struct packed {
    logic [BitTicksW-1:0] bit_ticks;
    logic [TimeoutW-1:0]  start_timeout_ticks;
    logic [GuardW-1:0]    guard_bits;
    logic [ReplyW-1:0]    reply_bytes;
  } cfg_t;

  typedef struct packed {
    phase_t              phase;
    logic [TimerW-1:0]   bit_timer;
    logic [TimeoutW-1:0] wait_timer;
    logic [IndexW-1:0]   bit_index;
    logic [7:0]          shift_reg;
    logic [ReplyW-1:0]   bytes_left;
    logic                reply_wanted;
    logic                final_pending;
  } state_t;

  typedef struct packed {
    logic       op;
    logic [7:0] tx_byte;
    logic       last_byte;
    logic       expect_reply;
    logic       line_in;
  } item_t;

  typedef struct packed {
    logic       line_out;
    logic       drive_enable;
    logic       byte_taken;
    logic       rx_valid;
    logic [7:0] rx_byte;
    logic       rx_last;
    logic       timed_out;
    logic       busy_res;
  } result_t;

endpackage
`default_nettype wire

>>> src/swut_cfg.sv
// apb register file holding the four configuration registers
`default_nettype none
module swut_cfg
  import swut_pkg::*;
(
  input  wire                 clk,
  input  wire                 rst,
  input  wire                 psel,
  input  wire                 penable,
  input  wire                 pwrite,
  input  wire  [ApbAddrW-1:0] paddr,
  input  wire  [ApbDataW-1:0] pwdata,
  output logic [ApbDataW-1:0] prdata,
  output logic                pready,
  output cfg_t                cfg
);

  reg_idx_t idx;
  logic     wr_en;

  assign pready = 1'b1;
  assign idx    = reg_idx_t'(paddr[3:2]);
  assign wr_en  = psel & penable & pwrite & pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.bit_ticks           <= BitTicksRst;
      cfg.start_timeout_ticks <= TimeoutRst;
      cfg.guard_bits          <= GuardRst;
      cfg.reply_bytes         <= ReplyRst;
    end else if (wr_en) begin
      case (idx)
        REG_BIT_TICKS: cfg.bit_ticks           <= pwdata[BitTicksW-1:0];
        REG_TIMEOUT:   cfg.start_timeout_ticks <= pwdata[TimeoutW-1:0];
        REG_GUARD:     cfg.guard_bits          <= pwdata[GuardW-1:0];
        REG_REPLY:     cfg.reply_bytes         <= pwdata[ReplyW-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (idx)
      REG_BIT_TICKS: prdata = ApbDataW'(cfg.bit_ticks);
      REG_TIMEOUT:   prdata = ApbDataW'(cfg.start_timeout_ticks);
      REG_GUARD:     prdata = ApbDataW'(cfg.guard_bits);
      REG_REPLY:     prdata = ApbDataW'(cfg.reply_bytes);
      default:       prdata = '0;
    endcase
  end

endmodule
`default_nettype wire

>>> src/swut_step.sv
// next-state and result logic for one clock tick of the transaction engine
`default_nettype none
module swut_step
  import swut_pkg::*;
(
  input  cfg_t    cfg,
  input  state_t  cur,
  input  item_t   item,
  output state_t  nxt,
  output result_t res
);

  logic [TimerW-1:0]   bt;
  logic [TimerW-1:0]   bt_half;
  logic [TimerW-1:0]   timer_inc;
  logic [TimerW-1:0]   target;
  logic [TimeoutW-1:0] wait_inc;
  logic [IndexW-1:0]   idx_inc;
  logic [ReplyW-1:0]   reply_eff;
  logic [ReplyW-1:0]   left_dec;
  logic [7:0]          shift_new;
  logic [2:0]          tx_sel;
  phase_t              guard_phase;

  // clamped bit time and reply length
  assign bt        = (cfg.bit_ticks < BitTicksMin) ? TimerW'(BitTicksMin)
                                                   : TimerW'(cfg.bit_ticks);
  assign bt_half   = bt + (bt >> 1);
  assign reply_eff = (cfg.reply_bytes == '0)    ? ReplyW'(1) :
                     (cfg.reply_bytes > ReplyMax) ? ReplyMax : cfg.reply_bytes;
  assign guard_phase = (cfg.guard_bits != '0) ? PH_GUARD : PH_IDLE;

  always_comb begin
    nxt = cur;
    res = '0;
    res.line_out     = 1'b1;
    res.drive_enable = 1'b1;
    res.busy_res     = 1'b1;

    // take an offered byte when idle or between request bytes
    if (cur.phase == PH_IDLE || cur.phase == PH_HOLD) begin
      if (item.op) begin
        res.byte_taken    = 1'b1;
        nxt.shift_reg     = item.tx_byte;
        nxt.final_pending = item.last_byte;
        nxt.reply_wanted  = item.expect_reply;
        nxt.phase         = PH_TX;
        nxt.bit_index     = '0;
        nxt.bit_timer     = '0;
      end else if (cur.phase == PH_IDLE) begin
        res.busy_res = 1'b0;
      end
    end

    timer_inc = nxt.bit_timer + TimerW'(1);
    wait_inc  = nxt.wait_timer + TimeoutW'(1);
    idx_inc   = nxt.bit_index + IndexW'(1);
    target    = (nxt.bit_index == '0) ? bt_half : bt;
    left_dec  = (nxt.bytes_left != '0) ? nxt.bytes_left - ReplyW'(1) : '0;
    tx_sel    = 3'(nxt.bit_index - IndexW'(1));
    shift_new = nxt.shift_reg | (8'(item.line_in) << nxt.bit_index[2:0]);

    case (nxt.phase)
      PH_TX: begin
        if (nxt.bit_index == '0) begin
          res.line_out = 1'b0;
        end else if (nxt.bit_index <= IndexW'(8)) begin
          res.line_out = nxt.shift_reg[tx_sel];
        end
        nxt.bit_timer = timer_inc;
        if (timer_inc >= bt) begin
          nxt.bit_timer = '0;
          nxt.bit_index = idx_inc;
          if (idx_inc >= TxBits) begin
            nxt.bit_index = '0;
            if (!nxt.final_pending) begin
              nxt.phase = PH_HOLD;
            end else if (nxt.reply_wanted) begin
              nxt.bytes_left = reply_eff;
              nxt.wait_timer = '0;
              nxt.phase      = PH_WAIT;
            end else begin
              nxt.phase = guard_phase;
            end
          end
        end
      end
      PH_WAIT: begin
        res.drive_enable = 1'b0;
        if (!item.line_in) begin
          nxt.phase     = PH_BITS;
          nxt.bit_timer = '0;
          nxt.bit_index = '0;
          nxt.shift_reg = '0;
        end else begin
          nxt.wait_timer = wait_inc;
          if (wait_inc >= cfg.start_timeout_ticks) begin
            res.rx_valid   = 1'b1;
            res.rx_byte    = TimeoutByte;
            res.rx_last    = 1'b1;
            res.timed_out  = 1'b1;
            nxt.bytes_left = '0;
            nxt.bit_timer  = '0;
            nxt.bit_index  = '0;
            nxt.phase      = guard_phase;
          end
        end
      end
      PH_BITS: begin
        res.drive_enable = 1'b0;
        nxt.bit_timer    = timer_inc;
        if (timer_inc >= target) begin
          nxt.shift_reg = shift_new;
          nxt.bit_timer = '0;
          nxt.bit_index = idx_inc;
          if (idx_inc >= RxBits) begin
            res.rx_valid   = 1'b1;
            res.rx_byte    = shift_new;
            nxt.bytes_left = left_dec;
            res.rx_last    = (left_dec == '0);
            nxt.bit_index  = '0;
            nxt.phase      = PH_TAIL;
          end
        end
      end
      PH_TAIL: begin
        res.drive_enable = 1'b0;
        nxt.bit_timer    = timer_inc;
        if (timer_inc >= bt_half) begin
          nxt.bit_timer = '0;
          if (nxt.bytes_left == '0) begin
            nxt.bit_index = '0;
            nxt.phase     = guard_phase;
          end else begin
            nxt.wait_timer = '0;
            nxt.phase      = PH_WAIT;
          end
        end
      end
      PH_GUARD: begin
        nxt.bit_timer = timer_inc;
        if (timer_inc >= bt) begin
          nxt.bit_timer = '0;
          nxt.bit_index = idx_inc;
          if ({1'b0, idx_inc} >= {1'b0, cfg.guard_bits}) begin
            nxt.bit_index = '0;
            nxt.phase     = PH_IDLE;
          end
        end
      end
      PH_HOLD, PH_IDLE: ;
      default: begin
        nxt.phase    = PH_IDLE;
        res.busy_res = 1'b0;
      end
    endcase
  end

endmodule
`default_nettype wire

>>> src/single_wire_uart_transaction_top.sv
// top level of the half-duplex single-wire uart transaction engine
//
//   channel   dir  handshake          payload
//   s_axis    in   s_tvalid/s_tready  tdata {line_in,expect_reply,tx_byte}, tuser op,
//                                     tlast last_byte
//   m_axis    out  m_tvalid/m_tready  tdata {busy_res,rx_byte,rx_valid,byte_taken,
//                                     drive_enable,line_out}, tuser timed_out,
//                                     tlast rx_last
//   apb       in   psel/penable       four configuration registers at 0x0..0xc
//
// one tick per transaction: every accepted input gives exactly one result in the
// next cycle, and an input is taken in every cycle while the result register is
// free or being drained. the engine state and result register sit behind one
// layer of logic (timer increment and compare). reset clears the engine to idle and
// loads the register defaults. a stall on the output side holds the input side off.
`default_nettype none
module single_wire_uart_transaction_top
  import swut_pkg::*;
(
  input  wire                 clk,
  input  wire                 rst,
  // s_tdata: tx_byte[7:0], expect_reply[8], line_in[9], zeros[15:10]
  input  wire  [15:0]         s_tdata,
  // s_tuser: op
  input  wire                 s_tuser,
  input  wire                 s_tlast,
  input  wire                 s_tvalid,
  output logic                s_tready,
  // m_tdata: line_out[0], drive_enable[1], byte_taken[2], rx_valid[3],
  //          rx_byte[11:4], busy_res[12], zeros[15:13]
  output logic [15:0]         m_tdata,
  // m_tuser: timed_out
  output logic                m_tuser,
  output logic                m_tlast,
  output logic                m_tvalid,
  input  wire                 m_tready,
  input  wire                 psel,
  input  wire                 penable,
  input  wire                 pwrite,
  input  wire  [ApbAddrW-1:0] paddr,
  input  wire  [ApbDataW-1:0] pwdata,
  output logic [ApbDataW-1:0] prdata,
  output logic                pready
);

  cfg_t    cfg;
  state_t  state;
  state_t  state_next;
  item_t   item;
  result_t res_next;
  result_t res;
  logic    in_take;

  swut_cfg u_cfg (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  assign item.op           = s_tuser;
  assign item.tx_byte      = s_tdata[7:0];
  assign item.expect_reply = s_tdata[8];
  assign item.line_in      = s_tdata[9];
  assign item.last_byte    = s_tlast;

  swut_step u_step (
    .cfg  (cfg),
    .cur  (state),
    .item (item),
    .nxt  (state_next),
    .res  (res_next)
  );

  assign s_tready = ~m_tvalid | m_tready;
  assign in_take  = s_tvalid & s_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      state.phase         <= PH_IDLE;
      state.bit_timer     <= '0;
      state.wait_timer    <= '0;
      state.bit_index     <= '0;
      state.shift_reg     <= '0;
      state.bytes_left    <= '0;
      state.reply_wanted  <= 1'b0;
      state.final_pending <= 1'b0;
      m_tvalid            <= 1'b0;
    end else if (in_take) begin
      state    <= state_next;
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  // result payload only moves with an accepted transaction
  always_ff @(posedge clk) begin
    if (in_take) begin
      res <= res_next;
    end
  end

  assign m_tdata = {3'b000, res.busy_res, res.rx_byte, res.rx_valid, res.byte_taken,
                    res.drive_enable, res.line_out};
  assign m_tuser = res.timed_out;
  assign m_tlast = res.rx_last;

endmodule
`default_nettype wire

>>> tb/tb_single_wire_uart_transaction_top.sv
// self-checking testbench of the single-wire uart transaction engine, tick by tick
`timescale 1ns / 100ps
module tb_single_wire_uart_transaction_top
  import swut_pkg::*;
();

  localparam int CycleLimit = 400000;

  typedef enum logic [1:0] {
    SLAVE_QUIET,
    SLAVE_REPLY,
    SLAVE_MIXED,
    SLAVE_NOISE
  } slave_mode_t;

  logic                clk = 1'b0;
  logic                rst;
  logic [15:0]         s_tdata;
  logic                s_tuser;
  logic                s_tlast;
  logic                s_tvalid;
  logic                s_tready;
  logic [15:0]         m_tdata;
  logic                m_tuser;
  logic                m_tlast;
  logic                m_tvalid;
  logic                m_tready;
  logic                psel;
  logic                penable;
  logic                pwrite;
  logic [ApbAddrW-1:0] paddr;
  logic [ApbDataW-1:0] pwdata;
  logic [ApbDataW-1:0] prdata;
  logic                pready;

  // engine model: shadow registers and state, kept in step with accepted ticks
  cfg_t        cfg_now;
  state_t      eng;
  result_t     due_results[$];
  logic        reply_wire[$];
  slave_mode_t slave_mode = SLAVE_REPLY;
  logic        gaps_on = 1'b1;
  int          req_left = 0;
  logic        req_reply = 1'b0;

  int errors = 0;
  int n_results = 0;
  int n_taken = 0;
  int n_rx = 0;
  int n_timeouts = 0;
  int n_settings = 0;

  single_wire_uart_transaction_top DUT (
    .clk     (clk),
    .rst     (rst),
    .s_tdata (s_tdata),
    .s_tuser (s_tuser),
    .s_tlast (s_tlast),
    .s_tvalid(s_tvalid),
    .s_tready(s_tready),
    .m_tdata (m_tdata),
    .m_tuser (m_tuser),
    .m_tlast (m_tlast),
    .m_tvalid(m_tvalid),
    .m_tready(m_tready),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  task automatic flag_mismatch(input string what, input logic [31:0] got,
                               input logic [31:0] want);
    errors++;
    if (errors <= 30)
      $display("mismatch %s: got %0h, expected %0h at %0t", what, got, want, $realtime);
  endtask

  function automatic logic [16:0] eff_bit_ticks();
    return (cfg_now.bit_ticks < BitTicksMin) ? 17'(BitTicksMin) : 17'(cfg_now.bit_ticks);
  endfunction

  function automatic logic [ReplyW-1:0] eff_reply_bytes();
    if (cfg_now.reply_bytes == '0) return 5'd1;
    return (cfg_now.reply_bytes > ReplyMax) ? ReplyMax : cfg_now.reply_bytes;
  endfunction

  function automatic void start_guard();
    eng.bit_timer = '0;
    eng.bit_index = '0;
    eng.phase = (cfg_now.guard_bits != '0) ? PH_GUARD : PH_IDLE;
  endfunction

  // advances the engine model by one tick and returns what the tick reports
  function automatic result_t step_engine(input item_t it);
    result_t r;
    logic [16:0] bt, bt15;
    r = '0;
    r.line_out = 1'b1;
    r.drive_enable = 1'b1;
    r.busy_res = 1'b1;
    bt = eff_bit_ticks();
    bt15 = bt + (bt >> 1);
    if (eng.phase == PH_IDLE || eng.phase == PH_HOLD) begin
      if (it.op) begin
        r.byte_taken = 1'b1;
        eng.shift_reg = it.tx_byte;
        eng.final_pending = it.last_byte;
        eng.reply_wanted = it.expect_reply;
        eng.phase = PH_TX;
        eng.bit_index = '0;
        eng.bit_timer = '0;
      end else if (eng.phase == PH_IDLE) begin
        r.busy_res = 1'b0;
      end
    end
    case (eng.phase)
      PH_TX: begin
        if (eng.bit_index == '0) r.line_out = 1'b0;
        else if (eng.bit_index <= 4'd8)
          r.line_out = eng.shift_reg[3'(eng.bit_index - 4'd1)];
        eng.bit_timer = eng.bit_timer + 17'd1;
        if (eng.bit_timer >= bt) begin
          eng.bit_timer = '0;
          eng.bit_index = eng.bit_index + 4'd1;
          if (eng.bit_index >= TxBits) begin
            eng.bit_index = '0;
            if (!eng.final_pending) begin
              eng.phase = PH_HOLD;
            end else if (eng.reply_wanted) begin
              eng.bytes_left = eff_reply_bytes();
              eng.wait_timer = '0;
              eng.phase = PH_WAIT;
            end else begin
              start_guard();
            end
          end
        end
      end
      PH_WAIT: begin
        r.drive_enable = 1'b0;
        if (!it.line_in) begin
          eng.phase = PH_BITS;
          eng.bit_timer = '0;
          eng.bit_index = '0;
          eng.shift_reg = '0;
        end else begin
          eng.wait_timer = eng.wait_timer + 20'd1;
          if (eng.wait_timer >= cfg_now.start_timeout_ticks) begin
            r.rx_valid = 1'b1;
            r.rx_byte = TimeoutByte;
            r.rx_last = 1'b1;
            r.timed_out = 1'b1;
            eng.bytes_left = '0;
            start_guard();
          end
        end
      end
      PH_BITS: begin
        r.drive_enable = 1'b0;
        eng.bit_timer = eng.bit_timer + 17'd1;
        // first sample sits mid-bit, half a bit past the start bit
        if (eng.bit_timer >= ((eng.bit_index == '0) ? bt15 : bt)) begin
          if (it.line_in) eng.shift_reg[eng.bit_index[2:0]] = 1'b1;
          eng.bit_timer = '0;
          eng.bit_index = eng.bit_index + 4'd1;
          if (eng.bit_index >= RxBits) begin
            r.rx_valid = 1'b1;
            r.rx_byte = eng.shift_reg;
            if (eng.bytes_left != '0) eng.bytes_left = eng.bytes_left - 5'd1;
            r.rx_last = (eng.bytes_left == '0);
            eng.bit_index = '0;
            eng.phase = PH_TAIL;
          end
        end
      end
      PH_TAIL: begin
        r.drive_enable = 1'b0;
        eng.bit_timer = eng.bit_timer + 17'd1;
        if (eng.bit_timer >= bt15) begin
          eng.bit_timer = '0;
          if (eng.bytes_left == '0) begin
            start_guard();
          end else begin
            eng.wait_timer = '0;
            eng.phase = PH_WAIT;
          end
        end
      end
      PH_GUARD: begin
        eng.bit_timer = eng.bit_timer + 17'd1;
        if (eng.bit_timer >= bt) begin
          eng.bit_timer = '0;
          eng.bit_index = eng.bit_index + 4'd1;
          if (eng.bit_index >= cfg_now.guard_bits) begin
            eng.bit_index = '0;
            eng.phase = PH_IDLE;
          end
        end
      end
      PH_HOLD, PH_IDLE: ;
      default: begin
        eng.phase = PH_IDLE;
        r.busy_res = 1'b0;
      end
    endcase
    return r;
  endfunction

  // the far end of the wire: one 8n1 frame, after a short or a long silence
  function automatic void queue_reply_frame();
    logic [7:0] b;
    int bt, lead;
    bt = int'(eff_bit_ticks());
    case ($urandom_range(0, 3))
      0: b = 8'h00;
      1: b = 8'hFF;
      default: b = 8'($urandom);
    endcase
    lead = $urandom_range(0, 2);
    if (slave_mode == SLAVE_MIXED && cfg_now.start_timeout_ticks <= 40 &&
        $urandom_range(0, 3) == 0)
      lead = $urandom_range(0, cfg_now.start_timeout_ticks + 3);
    repeat (lead) reply_wire.push_back(1'b1);
    repeat (bt) reply_wire.push_back(1'b0);
    for (int i = 0; i < 8; i++)
      repeat (bt) reply_wire.push_back(b[i]);
    repeat (bt) reply_wire.push_back(1'b1);
  endfunction

  // one tick: wire level from the far end, random gap, then the transaction
  task automatic drive_tick(input logic op, input logic [7:0] tx, input logic last,
                            input logic expr);
    item_t it;
    logic wire_lvl;
    int gap;
    if (reply_wire.size() == 0 && eng.phase == PH_WAIT &&
        (slave_mode == SLAVE_REPLY || slave_mode == SLAVE_MIXED))
      queue_reply_frame();
    if (slave_mode == SLAVE_NOISE) wire_lvl = 1'($urandom);
    else if (reply_wire.size() != 0) wire_lvl = reply_wire.pop_front();
    else if (eng.phase == PH_WAIT || eng.phase == PH_BITS || eng.phase == PH_TAIL)
      wire_lvl = 1'b1;
    else wire_lvl = 1'($urandom);
    it.op = op;
    it.tx_byte = tx;
    it.last_byte = last;
    it.expect_reply = expr;
    it.line_in = wire_lvl;
    gap = gaps_on ? $urandom_range(0, 13) : 0;
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata <= {6'd0, wire_lvl, expr, tx};
    s_tuser <= op;
    s_tlast <= last;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    due_results.push_back(step_engine(it));
  endtask

  task automatic apb_access(input logic wr, input reg_idx_t idx, input logic [31:0] wdata,
                            output logic [31:0] rdata);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= wr;
    paddr <= {idx, 2'b00};
    pwdata <= wdata;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    rdata = prdata;
    psel <= 1'b0;
    penable <= 1'b0;
    @(posedge clk);
  endtask

  task automatic check_all_regs();
    logic [31:0] rd, want;
    for (int i = 0; i < 4; i++) begin
      case (reg_idx_t'(i))
        REG_BIT_TICKS: want = 32'(cfg_now.bit_ticks);
        REG_TIMEOUT:   want = 32'(cfg_now.start_timeout_ticks);
        REG_GUARD:     want = 32'(cfg_now.guard_bits);
        default:       want = 32'(cfg_now.reply_bytes);
      endcase
      apb_access(1'b0, reg_idx_t'(i), 32'($urandom), rd);
      if (rd !== want) flag_mismatch("register readback", rd, want);
    end
  endtask

  // upper bits of pwdata carry junk, the registers keep only their own width
  task automatic set_cfg(input logic [15:0] bt, input logic [19:0] tmo, input logic [3:0] g,
                         input logic [4:0] rb);
    logic [31:0] rd;
    apb_access(1'b1, REG_BIT_TICKS, {16'($urandom), bt}, rd);
    apb_access(1'b1, REG_TIMEOUT, {12'($urandom), tmo}, rd);
    apb_access(1'b1, REG_GUARD, {28'($urandom), g}, rd);
    apb_access(1'b1, REG_REPLY, {27'($urandom), rb}, rd);
    cfg_now.bit_ticks = bt;
    cfg_now.start_timeout_ticks = tmo;
    cfg_now.guard_bits = g;
    cfg_now.reply_bytes = rb;
    n_settings++;
    check_all_regs();
  endtask

  // bring the engine back to idle and let every result drain
  task automatic finish_phase();
    slave_mode = SLAVE_REPLY;
    req_left = 0;
    while (eng.phase != PH_IDLE) begin
      if (eng.phase == PH_HOLD) drive_tick(1'b1, 8'($urandom), 1'b1, 1'b0);
      else drive_tick(1'b0, 8'($urandom), 1'($urandom), 1'($urandom));
    end
    s_tvalid <= 1'b0;
    while (due_results.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
    reply_wire.delete();
  endtask

  // plain ticks until the byte can be taken, with ignored offers mixed in
  task automatic offer_byte(input logic [7:0] b, input logic last, input logic expr);
    while (!(eng.phase == PH_IDLE || eng.phase == PH_HOLD))
      drive_tick($urandom_range(0, 3) == 0, ~b, 1'($urandom), 1'($urandom));
    drive_tick(1'b1, b, last, expr);
  endtask

  task automatic test_register_defaults();
    check_all_regs();
    drive_tick(1'b0, 8'h00, 1'b0, 1'b0);
    drive_tick(1'b0, 8'hFF, 1'b1, 1'b1);
    finish_phase();
  endtask

  task automatic test_register_extremes();
    set_cfg(16'hFFFF, 20'hFFFFF, 4'hF, 5'h1F);
    drive_tick(1'b0, 8'hFF, 1'b1, 1'b1);
    drive_tick(1'b0, 8'h00, 1'b0, 1'b0);
    finish_phase();
    // bit time below the minimum, zero timeout, zero guard, zero reply length
    set_cfg(16'd0, 20'd0, 4'd0, 5'd0);
    slave_mode = SLAVE_QUIET;
    offer_byte(8'hFF, 1'b1, 1'b1);
    while (eng.phase != PH_IDLE) drive_tick(1'b0, 8'h00, 1'b0, 1'b0);
    slave_mode = SLAVE_REPLY;
    offer_byte(8'h00, 1'b1, 1'b1);
    finish_phase();
    set_cfg(16'd1, 20'd1, 4'd1, 5'd17);
    offer_byte(8'hA5, 1'b1, 1'b0);
    finish_phase();
  endtask

  task automatic test_requests();
    set_cfg(16'd2, 20'd3, 4'd1, 5'd2);
    slave_mode = SLAVE_REPLY;
    offer_byte(8'h00, 1'b1, 1'b0);
    // unfinished request: wire held high until the next byte, which decides the reply
    offer_byte(8'hFF, 1'b0, 1'b1);
    while (eng.phase != PH_HOLD) drive_tick(1'b0, 8'h11, 1'b0, 1'b0);
    repeat (4) drive_tick(1'b0, 8'($urandom), 1'($urandom), 1'($urandom));
    offer_byte(8'h5A, 1'b1, 1'b0);
    offer_byte(8'h81, 1'b1, 1'b1);
    while (eng.phase != PH_IDLE) drive_tick(1'b0, 8'h00, 1'b0, 1'b0);
    slave_mode = SLAVE_QUIET;
    offer_byte(8'h3C, 1'b1, 1'b1);
    finish_phase();
  endtask

  task automatic random_phase(input logic [15:0] bt, input logic [19:0] tmo,
                              input logic [3:0] g, input logic [4:0] rb);
    logic op, last, expr;
    logic [7:0] tx;
    int n, pick;
    set_cfg(bt, tmo, g, rb);
    gaps_on = ($urandom_range(0, 3) != 0);
    n = $urandom_range(40, 55);
    repeat (n) begin
      tx = 8'($urandom);
      last = 1'($urandom);
      expr = 1'($urandom);
      op = 1'b0;
      if (eng.phase == PH_IDLE || eng.phase == PH_HOLD) begin
        if (req_left == 0) begin
          req_left = (eng.phase == PH_HOLD) ? 1 : $urandom_range(1, 3);
          req_reply = ($urandom_range(0, 3) != 0);
          pick = $urandom_range(0, 5);
          if (pick == 0) slave_mode = SLAVE_NOISE;
          else if (pick == 1 && cfg_now.start_timeout_ticks <= 64) slave_mode = SLAVE_QUIET;
          else slave_mode = SLAVE_MIXED;
        end
        if ($urandom_range(0, 2) != 0) begin
          op = 1'b1;
          last = (req_left == 1);
          // now and then a request ends early or runs on
          if ($urandom_range(0, 11) == 0) last = !last;
          if (last) expr = req_reply;
          req_left = last ? 0 : ((req_left > 1) ? req_left - 1 : 1);
        end
      end else if ($urandom_range(0, 7) == 0) begin
        op = 1'b1;
      end
      drive_tick(op, tx, last, expr);
    end
    finish_phase();
  endtask

  task automatic test_random_traffic();
    random_phase(16'd2, 20'd3, 4'd0, 5'd1);
    random_phase(16'd3, 20'd0, 4'd1, 5'd2);
    random_phase(16'd2, 20'hFFFFF, 4'd15, 5'd16);
    random_phase(16'd0, 20'd6, 4'd2, 5'd0);
    random_phase(16'd1, 20'd12, 4'd3, 5'd31);
    random_phase(16'd4, 20'd9, 4'd1, 5'd3);
    random_phase(16'd2, 20'd40, 4'd0, 5'd17);
    random_phase(16'd5, 20'd1, 4'd2, 5'd1);
    gaps_on = 1'b1;
  endtask

  // result side: random back-pressure, every transaction checked against the oldest tick
  initial begin : result_sink
    result_t want;
    int stall;
    m_tready <= 1'b0;
    @(posedge clk);
    while (rst) @(posedge clk);
    forever begin
      stall = gaps_on ? $urandom_range(0, 13) : 0;
      if (stall > 0) begin
        m_tready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      m_tready <= 1'b1;
      @(posedge clk);
      while (!m_tvalid) @(posedge clk);
      if (due_results.size() == 0) begin
        flag_mismatch("result with no tick waiting", 32'(m_tdata), 32'd0);
      end else begin
        want = due_results.pop_front();
        if (m_tdata[0] !== want.line_out)
          flag_mismatch("line_out", 32'(m_tdata[0]), 32'(want.line_out));
        if (m_tdata[1] !== want.drive_enable)
          flag_mismatch("drive_enable", 32'(m_tdata[1]), 32'(want.drive_enable));
        if (m_tdata[2] !== want.byte_taken)
          flag_mismatch("byte_taken", 32'(m_tdata[2]), 32'(want.byte_taken));
        if (m_tdata[3] !== want.rx_valid)
          flag_mismatch("rx_valid", 32'(m_tdata[3]), 32'(want.rx_valid));
        if (m_tdata[11:4] !== want.rx_byte)
          flag_mismatch("rx_byte", 32'(m_tdata[11:4]), 32'(want.rx_byte));
        if (m_tdata[12] !== want.busy_res)
          flag_mismatch("busy_res", 32'(m_tdata[12]), 32'(want.busy_res));
        if (m_tlast !== want.rx_last)
          flag_mismatch("rx_last", 32'(m_tlast), 32'(want.rx_last));
        if (m_tuser !== want.timed_out)
          flag_mismatch("timed_out", 32'(m_tuser), 32'(want.timed_out));
        n_results++;
        if (want.byte_taken) n_taken++;
        if (want.timed_out) n_timeouts++;
        else if (want.rx_valid) n_rx++;
      end
    end
  end

  initial begin : watchdog
    int cycles;
    cycles = 0;
    while (cycles < CycleLimit) begin
      @(posedge clk);
      cycles++;
    end
    $display("tb_single_wire_uart_transaction_top: done, errors");
    $finish;
  end

  initial begin
    cfg_now.bit_ticks = BitTicksRst;
    cfg_now.start_timeout_ticks = TimeoutRst;
    cfg_now.guard_bits = GuardRst;
    cfg_now.reply_bytes = ReplyRst;
    eng = '0;
    eng.phase = PH_IDLE;
    rst <= 1'b1;
    s_tvalid <= 1'b0;
    s_tdata <= '0;
    s_tuser <= 1'b0;
    s_tlast <= 1'b0;
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    paddr <= '0;
    pwdata <= '0;
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_register_defaults();
    test_register_extremes();
    test_requests();
    test_random_traffic();
    repeat (20) @(posedge clk);
    if (due_results.size() != 0)
      flag_mismatch("ticks left without a result", 32'(due_results.size()), 32'd0);
    $display("summary: %0d ticks checked, %0d bytes sent, %0d reply bytes received",
             n_results, n_taken, n_rx);
    $display("summary: %0d start-bit timeouts over %0d register settings, %0d mismatches",
             n_timeouts, n_settings, errors);
    if (errors == 0) begin
      $display("tb_single_wire_uart_transaction_top: done, clean");
    end else begin
      $display("tb_single_wire_uart_transaction_top: done, errors");
    end
    $finish;
  end

endmodule
